// ----- design/dms_pkg.sv -----
// dms_pkg: shared constants, command/status structs and codes for the
// DNA minimiser selector. No dependencies.
`default_nettype none
package dms_pkg;

  localparam int MAX_BASES_DEF = 1024;
  localparam int MAX_K_DEF     = 32;

  localparam int HARD_W = 5;
  localparam int K_W    = 6;
  localparam int WIN_W  = 11;
  localparam int POS_W  = 10;
  localparam int BITS_W = 64;
  localparam int ST_W   = 2;
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 11;
  localparam int CRIT_W = 16;
  localparam int OP_W   = 5;

  localparam logic [1:0] PH_LOAD = 2'd0;
  localparam logic [1:0] PH_SEL  = 2'd1;
  localparam logic [1:0] PH_FIN  = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  localparam logic [ST_W-1:0] ST_LOADED = 2'd0;
  localparam logic [ST_W-1:0] ST_KMER   = 2'd1;
  localparam logic [ST_W-1:0] ST_DONE   = 2'd2;
  localparam logic [ST_W-1:0] ST_ERROR  = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_HARD = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_KLEN = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_WLEN = 2'd2;

  localparam logic [OP_W-1:0] OP_NOP        = 5'd0;
  localparam logic [OP_W-1:0] OP_CAP        = 5'd1;
  localparam logic [OP_W-1:0] OP_LD_RESTART = 5'd2;
  localparam logic [OP_W-1:0] OP_LD_WRITE   = 5'd3;
  localparam logic [OP_W-1:0] OP_SET_ERR    = 5'd4;
  localparam logic [OP_W-1:0] OP_SET_FIN    = 5'd5;
  localparam logic [OP_W-1:0] OP_SEL_START  = 5'd6;
  localparam logic [OP_W-1:0] OP_CLR        = 5'd7;
  localparam logic [OP_W-1:0] OP_SCAN       = 5'd8;
  localparam logic [OP_W-1:0] OP_LB_INIT    = 5'd9;
  localparam logic [OP_W-1:0] OP_LB_RD      = 5'd10;
  localparam logic [OP_W-1:0] OP_LB_SH      = 5'd11;
  localparam logic [OP_W-1:0] OP_MARK_INIT  = 5'd12;
  localparam logic [OP_W-1:0] OP_MARK       = 5'd13;
  localparam logic [OP_W-1:0] OP_ANY_INIT   = 5'd14;
  localparam logic [OP_W-1:0] OP_ANY_RD     = 5'd15;
  localparam logic [OP_W-1:0] OP_ANY_NX     = 5'd16;
  localparam logic [OP_W-1:0] OP_NEXT_PASS  = 5'd17;
  localparam logic [OP_W-1:0] OP_RESP       = 5'd18;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic [ST_W-1:0] resp;
  } dms_cmd_t;

  typedef struct packed {
    logic       in_cmd;
    logic       in_last;
    logic [1:0] phase;
    logic       len_full;
    logic       geom_ok;
    logic       scan_more;
    logic       win_q;
    logic       lb_done;
    logic       lb_match;
    logic       km_done;
    logic       mark_done;
    logic       idx_last;
    logic       clr_last;
    logic       out_free;
  } dms_stat_t;

endpackage
`default_nettype wire

// ----- design/dms_dp.sv -----
// dms_dp: datapath of the minimiser selector: config registers, base store,
// window map, scan/criterion registers and the output register. Uses dms_pkg.
`default_nettype none
module dms_dp #(
  parameter int MAX_BASES = dms_pkg::MAX_BASES_DEF,
  parameter int MAX_K     = dms_pkg::MAX_K_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_cmd,
  input  wire  [1:0]                   in_base,
  input  wire                          in_last_base,
  input  wire                          cfg_valid,
  input  wire  [dms_pkg::CFG_IW-1:0]   cfg_index,
  input  wire  [dms_pkg::CFG_DW-1:0]   cfg_data,
  input  dms_pkg::dms_cmd_t            cmd,
  output dms_pkg::dms_stat_t           stat,
  input  wire                          out_ready,
  output logic                         out_valid,
  output logic [dms_pkg::ST_W-1:0]     out_status,
  output logic [dms_pkg::POS_W-1:0]    out_kmer_pos,
  output logic [dms_pkg::BITS_W-1:0]   out_kmer_bits
);

  localparam int AW    = $clog2(MAX_BASES);
  localparam int LEN_W = $clog2(MAX_BASES + 1);
  localparam int CMP_W = ((LEN_W > dms_pkg::WIN_W) ? LEN_W : dms_pkg::WIN_W) + 1;
  localparam int BI_W  = ((LEN_W > dms_pkg::K_W) ? LEN_W : dms_pkg::K_W) + 1;

  logic [dms_pkg::HARD_W-1:0] hard_r;
  logic [dms_pkg::K_W-1:0]    klen_r;
  logic [dms_pkg::WIN_W-1:0]  wlen_r;

  logic                       cmd_r, last_r;
  logic [1:0]                 base_r;
  logic [1:0]                 phase_r;
  logic [LEN_W-1:0]           len_r, scan_r, lf_r, pos_r, idx_r;
  logic [dms_pkg::CRIT_W-1:0] crit_r;
  logic [dms_pkg::K_W-1:0]    cnt_r;
  logic [dms_pkg::BITS_W-1:0] acc_r;
  logic                       inr_r, win_q_r;
  logic [1:0]                 base_q_r;

  logic [1:0] base_mem [MAX_BASES];
  logic       win_mem  [MAX_BASES];

  logic [CMP_W-1:0]           len_c, k_c, w_c, e_c, pos_c;
  logic [LEN_W-1:0]           e_l, e_m1, hi, lo_a, lo, idx_clip, scan_clip;
  logic                       geom_ok;
  logic [dms_pkg::HARD_W-1:0] h_eff;
  logic [dms_pkg::CRIT_W-1:0] mask;
  logic [3:0]                 nb;
  logic [BI_W-1:0]            bidx;
  logic [AW-1:0]              win_addr;
  logic [dms_pkg::CRIT_W-1:0] lead;

  always_comb begin
    len_c     = CMP_W'(len_r);
    k_c       = CMP_W'(klen_r);
    w_c       = CMP_W'(wlen_r);
    pos_c     = CMP_W'(pos_r);
    geom_ok   = (k_c != '0) && (k_c <= CMP_W'(MAX_K)) && (w_c != '0) &&
                (k_c <= w_c) && (w_c <= len_c);
    e_c       = len_c - w_c + CMP_W'(1);
    e_l       = LEN_W'(e_c);
    e_m1      = e_l - LEN_W'(1);
    h_eff     = (hard_r > 5'd16) ? 5'd16 : hard_r;
    mask      = dms_pkg::CRIT_W'((17'd1 << h_eff) - 17'd1);
    nb        = 4'((h_eff + 5'd1) >> 1);
    hi        = (pos_r < e_l) ? pos_r : e_l;
    lo_a      = (pos_c >= w_c) ? LEN_W'(pos_c - w_c) : '0;
    lo        = (lo_a > lf_r) ? lo_a : lf_r;
    idx_clip  = (idx_r >= e_l) ? e_m1 : idx_r;
    scan_clip = (scan_r >= e_l) ? e_m1 : scan_r;
    // clearing covers every window a later geometry can reach (E <= length)
    win_addr  = (cmd.op == dms_pkg::OP_SCAN) ? scan_clip[AW-1:0] :
                (cmd.op == dms_pkg::OP_CLR)  ? idx_r[AW-1:0] : idx_clip[AW-1:0];
    bidx      = BI_W'(pos_r) + BI_W'(cnt_r);
    lead      = acc_r[dms_pkg::CRIT_W-1:0] >> h_eff[0];
  end

  always_comb begin
    stat.in_cmd    = cmd_r;
    stat.in_last   = last_r;
    stat.phase     = phase_r;
    stat.len_full  = (CMP_W'(len_r) >= CMP_W'(MAX_BASES));
    stat.geom_ok   = geom_ok;
    stat.scan_more = (CMP_W'(scan_r) + k_c) <= len_c;
    stat.win_q     = win_q_r;
    stat.lb_done   = (cnt_r == dms_pkg::K_W'(nb));
    stat.lb_match  = (lead == (crit_r & mask));
    stat.km_done   = (cnt_r == klen_r);
    stat.mark_done = (idx_r > hi);
    stat.idx_last  = (idx_r == e_m1);
    stat.clr_last  = (idx_r == (len_r - LEN_W'(1)));
    stat.out_free  = !out_valid || out_ready;
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.op == dms_pkg::OP_LD_WRITE) begin
      base_mem[len_r[AW-1:0]] <= base_r;
    end
    base_q_r <= base_mem[bidx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.op == dms_pkg::OP_CLR) begin
      win_mem[win_addr] <= 1'b1;
    end else if (cmd.op == dms_pkg::OP_MARK) begin
      win_mem[win_addr] <= 1'b0;
    end
    win_q_r <= win_mem[win_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hard_r    <= 5'd4;
      klen_r    <= 6'd16;
      wlen_r    <= 11'd32;
      phase_r   <= dms_pkg::PH_LOAD;
      len_r     <= '0;
      crit_r    <= '0;
      scan_r    <= '0;
      lf_r      <= '0;
      idx_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          dms_pkg::CFG_HARD: hard_r <= cfg_data[dms_pkg::HARD_W-1:0];
          dms_pkg::CFG_KLEN: klen_r <= cfg_data[dms_pkg::K_W-1:0];
          dms_pkg::CFG_WLEN: wlen_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == dms_pkg::OP_RESP) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (cmd.op)
        dms_pkg::OP_LD_RESTART: begin
          len_r   <= '0;
          phase_r <= dms_pkg::PH_LOAD;
        end
        dms_pkg::OP_LD_WRITE: len_r   <= len_r + LEN_W'(1);
        dms_pkg::OP_SET_ERR:  phase_r <= dms_pkg::PH_ERR;
        dms_pkg::OP_SET_FIN:  phase_r <= dms_pkg::PH_FIN;
        dms_pkg::OP_SEL_START: begin
          crit_r  <= '0;
          scan_r  <= '0;
          lf_r    <= '0;
          idx_r   <= '0;
          phase_r <= dms_pkg::PH_SEL;
        end
        dms_pkg::OP_CLR:  idx_r  <= idx_r + LEN_W'(1);
        dms_pkg::OP_SCAN: scan_r <= scan_r + LEN_W'(1);
        dms_pkg::OP_MARK_INIT: begin
          idx_r <= lo;
          lf_r  <= pos_r;
        end
        dms_pkg::OP_MARK:     idx_r <= idx_r + LEN_W'(1);
        dms_pkg::OP_ANY_INIT: idx_r <= '0;
        dms_pkg::OP_ANY_NX:   idx_r <= idx_r + LEN_W'(1);
        dms_pkg::OP_NEXT_PASS: begin
          crit_r <= (crit_r + dms_pkg::CRIT_W'(1)) & mask;
          scan_r <= '0;
          lf_r   <= '0;
        end
        default: ;
      endcase
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (cmd.op)
      dms_pkg::OP_CAP: begin
        cmd_r  <= in_cmd;
        base_r <= in_base;
        last_r <= in_last_base;
      end
      dms_pkg::OP_SCAN: pos_r <= scan_r;
      dms_pkg::OP_LB_INIT: begin
        cnt_r <= '0;
        acc_r <= '0;
      end
      dms_pkg::OP_LB_RD: inr_r <= (bidx < BI_W'(len_r));
      dms_pkg::OP_LB_SH: begin
        acc_r <= {acc_r[dms_pkg::BITS_W-3:0], (inr_r ? base_q_r : 2'b00)};
        cnt_r <= cnt_r + dms_pkg::K_W'(1);
      end
      dms_pkg::OP_RESP: begin
        out_status    <= cmd.resp;
        out_kmer_pos  <= (cmd.resp == dms_pkg::ST_KMER) ? dms_pkg::POS_W'(pos_r) : '0;
        out_kmer_bits <= (cmd.resp == dms_pkg::ST_KMER) ? acc_r : '0;
      end
      default: ;
    endcase
  end

  a_resp_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dms_pkg::OP_RESP) |-> (!out_valid || out_ready))
    else $error("result word overwritten");
  a_sel_len: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == dms_pkg::PH_SEL) |-> (len_r != '0))
    else $error("selecting with empty sequence");
  a_mark_rng: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dms_pkg::OP_MARK) |-> (LEN_W'(win_addr) < e_l))
    else $error("window mark out of range");
  a_ld_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == dms_pkg::OP_LD_WRITE) |-> !stat.len_full)
    else $error("base store overflow write");

endmodule
`default_nettype wire

// ----- design/dms_ctrl.sv -----
// dms_ctrl: controller state machine sequencing loads, the clearing pass,
// scans, window marking and k-mer gathering. Uses dms_pkg.
`default_nettype none
module dms_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_ready,
  input  dms_pkg::dms_stat_t  stat,
  output dms_pkg::dms_cmd_t   cmd
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_LD   = 4'd2;
  localparam logic [3:0] S_GEO  = 4'd3;
  localparam logic [3:0] S_CLR  = 4'd4;
  localparam logic [3:0] S_SCAN = 4'd5;
  localparam logic [3:0] S_SCHK = 4'd6;
  localparam logic [3:0] S_LBR  = 4'd7;
  localparam logic [3:0] S_LBS  = 4'd8;
  localparam logic [3:0] S_MARK = 4'd9;
  localparam logic [3:0] S_KMR  = 4'd10;
  localparam logic [3:0] S_KMS  = 4'd11;
  localparam logic [3:0] S_ANYR = 4'd12;
  localparam logic [3:0] S_ANYC = 4'd13;
  localparam logic [3:0] S_RESP = 4'd14;

  logic [3:0]               state_r, state_nxt;
  logic [dms_pkg::ST_W-1:0] resp_r, resp_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    resp_nxt  = resp_r;
    cmd.op    = dms_pkg::OP_NOP;
    cmd.resp  = resp_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = dms_pkg::OP_CAP;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!stat.in_cmd) begin
          if (stat.phase != dms_pkg::PH_LOAD) cmd.op = dms_pkg::OP_LD_RESTART;
          state_nxt = S_LD;
        end else if (stat.phase == dms_pkg::PH_FIN) begin
          resp_nxt  = dms_pkg::ST_DONE;
          state_nxt = S_RESP;
        end else if (stat.phase != dms_pkg::PH_SEL) begin
          resp_nxt  = dms_pkg::ST_ERROR;
          state_nxt = S_RESP;
        end else if (!stat.geom_ok) begin
          cmd.op    = dms_pkg::OP_SET_ERR;
          resp_nxt  = dms_pkg::ST_ERROR;
          state_nxt = S_RESP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_LD: begin
        if (stat.len_full) begin
          cmd.op    = dms_pkg::OP_SET_ERR;
          resp_nxt  = dms_pkg::ST_ERROR;
          state_nxt = S_RESP;
        end else begin
          cmd.op = dms_pkg::OP_LD_WRITE;
          if (stat.in_last) begin
            state_nxt = S_GEO;
          end else begin
            resp_nxt  = dms_pkg::ST_LOADED;
            state_nxt = S_RESP;
          end
        end
      end
      S_GEO: begin
        if (!stat.geom_ok) begin
          cmd.op    = dms_pkg::OP_SET_ERR;
          resp_nxt  = dms_pkg::ST_ERROR;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = dms_pkg::OP_SEL_START;
          state_nxt = S_CLR;
        end
      end
      S_CLR: begin
        cmd.op = dms_pkg::OP_CLR;
        if (stat.clr_last) begin
          resp_nxt  = dms_pkg::ST_LOADED;
          state_nxt = S_RESP;
        end
      end
      S_SCAN: begin
        if (stat.scan_more) begin
          cmd.op    = dms_pkg::OP_SCAN;
          state_nxt = S_SCHK;
        end else begin
          cmd.op    = dms_pkg::OP_ANY_INIT;
          state_nxt = S_ANYR;
        end
      end
      S_SCHK: begin
        if (stat.win_q) begin
          cmd.op    = dms_pkg::OP_LB_INIT;
          state_nxt = S_LBR;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_LBR: begin
        if (stat.lb_done) begin
          if (stat.lb_match) begin
            cmd.op    = dms_pkg::OP_MARK_INIT;
            state_nxt = S_MARK;
          end else begin
            state_nxt = S_SCAN;
          end
        end else begin
          cmd.op    = dms_pkg::OP_LB_RD;
          state_nxt = S_LBS;
        end
      end
      S_LBS: begin
        cmd.op    = dms_pkg::OP_LB_SH;
        state_nxt = S_LBR;
      end
      S_MARK: begin
        if (stat.mark_done) begin
          cmd.op    = dms_pkg::OP_LB_INIT;
          state_nxt = S_KMR;
        end else begin
          cmd.op = dms_pkg::OP_MARK;
        end
      end
      S_KMR: begin
        if (stat.km_done) begin
          resp_nxt  = dms_pkg::ST_KMER;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = dms_pkg::OP_LB_RD;
          state_nxt = S_KMS;
        end
      end
      S_KMS: begin
        cmd.op    = dms_pkg::OP_LB_SH;
        state_nxt = S_KMR;
      end
      S_ANYR: begin
        cmd.op    = dms_pkg::OP_ANY_RD;
        state_nxt = S_ANYC;
      end
      S_ANYC: begin
        if (stat.win_q) begin
          cmd.op    = dms_pkg::OP_NEXT_PASS;
          state_nxt = S_SCAN;
        end else if (stat.idx_last) begin
          cmd.op    = dms_pkg::OP_SET_FIN;
          resp_nxt  = dms_pkg::ST_DONE;
          state_nxt = S_RESP;
        end else begin
          cmd.op    = dms_pkg::OP_ANY_NX;
          state_nxt = S_ANYR;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.op    = dms_pkg::OP_RESP;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= dms_pkg::ST_LOADED;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/dna_minimiser_selector_unit.sv -----
// dna_minimiser_selector_unit: top level joining dms_ctrl and dms_dp.
// Depends on dms_pkg, dms_ctrl, dms_dp.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_ready  | cmd, base, last_base
//  out_    | output    | out_valid/out_ready| status, kmer_pos, kmer_bits
//  cfg_    | input     | cfg_valid/cfg_ready| index, data (always ready)
//
// One word is worked on at a time. The last base of a load adds a geometry
// check and a clearing pass over the first length entries of the map.
// A fetch scans positions, reads ceil(h/2) leading bases for each empty window
// tested, then marks the windows it covers and gathers the k-mer; a pass end
// sweeps the window map.
// Reset is synchronous; the result register holds a word while out_ready is low.
`default_nettype none
module dna_minimiser_selector_unit #(
  parameter int MAX_BASES = dms_pkg::MAX_BASES_DEF,
  parameter int MAX_K     = dms_pkg::MAX_K_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_valid,
  output logic                         in_ready,
  input  wire                          in_cmd,
  input  wire  [1:0]                   in_base,
  input  wire                          in_last_base,
  output logic                         out_valid,
  input  wire                          out_ready,
  output logic [dms_pkg::ST_W-1:0]     out_status,
  output logic [dms_pkg::POS_W-1:0]    out_kmer_pos,
  output logic [dms_pkg::BITS_W-1:0]   out_kmer_bits,
  input  wire                          cfg_valid,
  output logic                         cfg_ready,
  input  wire  [dms_pkg::CFG_IW-1:0]   cfg_index,
  input  wire  [dms_pkg::CFG_DW-1:0]   cfg_data
);

  dms_pkg::dms_cmd_t  cmd;
  dms_pkg::dms_stat_t stat;

  assign cfg_ready = 1'b1;

  dms_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dms_dp #(
    .MAX_BASES (MAX_BASES),
    .MAX_K     (MAX_K)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_cmd        (in_cmd),
    .in_base       (in_base),
    .in_last_base  (in_last_base),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .out_ready     (out_ready),
    .out_valid     (out_valid),
    .out_status    (out_status),
    .out_kmer_pos  (out_kmer_pos),
    .out_kmer_bits (out_kmer_bits)
  );

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
// tb: self-checking testbench for dna_minimiser_selector_unit.
// Drives loads and fetches with a built-in selection predictor and
// random idling on both sides; depends on dms_pkg and the design files.
`default_nettype none
module tb;

  typedef struct packed {
    logic [dms_pkg::ST_W-1:0]   status;
    logic [dms_pkg::POS_W-1:0]  pos;
    logic [dms_pkg::BITS_W-1:0] bits;
  } res_word_t;

  localparam bit CMD_LOAD  = 1'b0;
  localparam bit CMD_FETCH = 1'b1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_cmd = 1'b0, in_last_base = 1'b0;
  logic [1:0] in_base = 2'd0;
  logic in_ready, out_valid;
  logic out_ready = 1'b0;
  logic [dms_pkg::ST_W-1:0] out_status;
  logic [dms_pkg::POS_W-1:0] out_kmer_pos;
  logic [dms_pkg::BITS_W-1:0] out_kmer_bits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [dms_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [dms_pkg::CFG_DW-1:0] cfg_data = '0;

  dna_minimiser_selector_unit u_top (.*);

  always #10 clk = ~clk;

  // predictor state
  int unsigned hard_r, klen_r, wlen_r;
  bit [1:0] seq_mem [dms_pkg::MAX_BASES_DEF];
  bit win_open [dms_pkg::MAX_BASES_DEF];
  int unsigned seq_len, crit, scan_at, last_hit;
  logic [1:0] sel_phase;

  res_word_t pending_words[$];
  int n_items, n_kmers, n_bad;
  bit calm;

  function automatic bit geom_ok();
    return klen_r >= 1 && klen_r <= dms_pkg::MAX_K_DEF && wlen_r >= 1 &&
           klen_r <= wlen_r && wlen_r <= seq_len;
  endfunction

  function automatic int unsigned head_bits(int unsigned p, int unsigned h);
    int unsigned v, bp;
    v = 0;
    for (int unsigned b = 0; b < h; b++) begin
      bp = 2 * p + b;
      v = v << 1;
      if ((bp >> 1) < seq_len)
        v |= (bp & 1) ? seq_mem[bp >> 1][0] : seq_mem[bp >> 1][1];
    end
    return v;
  endfunction

  function automatic res_word_t predict_word(bit c, bit [1:0] b, bit lst);
    res_word_t r;
    int unsigned e, h, mask, i, lo, hi;
    bit emp, any;
    r = '0;
    if (c == CMD_LOAD) begin
      if (sel_phase != dms_pkg::PH_LOAD) begin
        seq_len = 0;
        sel_phase = dms_pkg::PH_LOAD;
      end
      if (seq_len >= dms_pkg::MAX_BASES_DEF) begin
        sel_phase = dms_pkg::PH_ERR;
        r.status = dms_pkg::ST_ERROR;
        return r;
      end
      seq_mem[seq_len] = b;
      seq_len++;
      r.status = dms_pkg::ST_LOADED;
      if (lst) begin
        if (!geom_ok()) begin
          sel_phase = dms_pkg::PH_ERR;
          r.status = dms_pkg::ST_ERROR;
          return r;
        end
        foreach (win_open[j]) win_open[j] = 1'b1;
        crit = 0; scan_at = 0; last_hit = 0;
        sel_phase = dms_pkg::PH_SEL;
      end
      return r;
    end
    if (sel_phase == dms_pkg::PH_FIN) begin r.status = dms_pkg::ST_DONE; return r; end
    if (sel_phase != dms_pkg::PH_SEL || !geom_ok()) begin
      if (sel_phase == dms_pkg::PH_SEL) sel_phase = dms_pkg::PH_ERR;
      r.status = dms_pkg::ST_ERROR;
      return r;
    end
    e = seq_len - wlen_r + 1;
    h = (hard_r > 16) ? 16 : hard_r;
    mask = (1 << h) - 1;
    while (1) begin
      while (scan_at + klen_r <= seq_len) begin
        i = scan_at;
        scan_at++;
        emp = (i >= e) ? win_open[e-1] : win_open[i];
        if (emp && head_bits(i, h) == (crit & mask)) begin
          lo = (i >= wlen_r) ? i - wlen_r : 0;
          if (last_hit > lo) lo = last_hit;
          hi = (i < e) ? i : e;
          for (int unsigned j = lo; j <= hi; j++) win_open[(j >= e) ? e - 1 : j] = 1'b0;
          last_hit = i;
          r.status = dms_pkg::ST_KMER;
          r.pos = i[dms_pkg::POS_W-1:0];
          for (int unsigned t = 0; t < klen_r; t++) r.bits = (r.bits << 2) | seq_mem[i + t];
          return r;
        end
      end
      any = 1'b0;
      for (int unsigned j = 0; j < e; j++) if (win_open[j]) any = 1'b1;
      if (!any) begin
        sel_phase = dms_pkg::PH_FIN;
        r.status = dms_pkg::ST_DONE;
        return r;
      end
      crit = (crit + 1) & mask;
      scan_at = 0; last_hit = 0;
    end
  endfunction

  task automatic send_word(bit c, bit [1:0] b, bit lst,
                           output logic [dms_pkg::ST_W-1:0] st);
    res_word_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 23) @(negedge clk);
    in_valid <= 1'b1; in_cmd <= c; in_base <= b; in_last_base <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = predict_word(c, b, lst);
    pending_words = {pending_words, r};
    n_items++;
    st = r.status;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pending_words.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [dms_pkg::CFG_IW-1:0] idx, int unsigned val);
    drain();
    repeat (40) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val[dms_pkg::CFG_DW-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == dms_pkg::CFG_HARD) hard_r = val & 5'h1F;
    else if (idx == dms_pkg::CFG_KLEN) klen_r = val & 6'h3F;
    else if (idx == dms_pkg::CFG_WLEN) wlen_r = val & 11'h7FF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_geom(int unsigned h, int unsigned k, int unsigned w);
    write_reg(dms_pkg::CFG_HARD, h);
    write_reg(dms_pkg::CFG_KLEN, k);
    write_reg(dms_pkg::CFG_WLEN, w);
  endtask

  task automatic load_seq(int unsigned len, bit zeros);
    logic [dms_pkg::ST_W-1:0] st;
    for (int unsigned n = 0; n < len; n++)
      send_word(CMD_LOAD, zeros ? 2'd0 : 2'($urandom_range(0, 3)), n == len - 1, st);
  endtask

  task automatic fetch_all(int unsigned extra);
    logic [dms_pkg::ST_W-1:0] st;
    int unsigned cnt;
    cnt = 0;
    do begin
      send_word(CMD_FETCH, 2'($urandom_range(0, 3)), 1'($urandom), st);
      cnt++;
    end while (st == dms_pkg::ST_KMER && cnt < 300);
    repeat (extra) send_word(CMD_FETCH, 2'd3, 1'b1, st);
  endtask

  task automatic test_directed();
    logic [dms_pkg::ST_W-1:0] st;
    send_word(CMD_FETCH, 2'd0, 1'b0, st);        // fetch while loading
    set_geom(2, 3, 5);
    send_word(CMD_LOAD, 2'd0, 1'b0, st);
    send_word(CMD_LOAD, 2'd3, 1'b0, st);
    send_word(CMD_LOAD, 2'd1, 1'b0, st);
    send_word(CMD_LOAD, 2'd2, 1'b0, st);
    send_word(CMD_LOAD, 2'd3, 1'b0, st);
    send_word(CMD_LOAD, 2'd0, 1'b0, st);
    send_word(CMD_LOAD, 2'd3, 1'b1, st);
    fetch_all(1);
    set_geom(0, 32, 32);                          // zero hardness, longest k
    load_seq(36, 0);
    fetch_all(0);
    set_geom(31, 1, 3);                           // hardness past 16, bits past end
    load_seq(4, 1);
    fetch_all(1);
  endtask

  task automatic test_bad_geometry();
    logic [dms_pkg::ST_W-1:0] st;
    set_geom(1, 2, 1024);                         // w > length
    load_seq(6, 0);
    send_word(CMD_FETCH, 2'd0, 1'b0, st);
    write_reg(dms_pkg::CFG_WLEN, 0);
    load_seq(3, 0);
    set_geom(1, 0, 2);
    load_seq(3, 0);
    set_geom(1, 40, 63);
    load_seq(3, 0);
    set_geom(1, 4, 3);                            // k > w
    load_seq(5, 0);
    set_geom(1, 2, 3);                            // geometry broken mid-selection
    load_seq(8, 0);
    send_word(CMD_FETCH, 2'd0, 1'b0, st);
    write_reg(dms_pkg::CFG_KLEN, 5);
    send_word(CMD_FETCH, 2'd0, 1'b0, st);
    send_word(CMD_FETCH, 2'd0, 1'b0, st);
  endtask

  task automatic test_overflow();
    logic [dms_pkg::ST_W-1:0] st;
    calm = 1'b1;
    for (int n = 0; n <= dms_pkg::MAX_BASES_DEF; n++)
      send_word(CMD_LOAD, 2'($urandom_range(0, 3)), 1'b0, st);
    send_word(CMD_FETCH, 2'd0, 1'b0, st);
    calm = 1'b0;
  endtask

  task automatic test_random(int target);
    logic [dms_pkg::ST_W-1:0] st;
    int unsigned k, len, w, pick;
    while (n_items < target) begin
      pick = $urandom_range(0, 99);
      k = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
      len = k + $urandom_range(0, 30);
      w = $urandom_range(k, len);
      if (pick < 5) w = len + 1;
      set_geom($urandom_range(0, 9) == 0 ? 4 : $urandom_range(0, 3), k, w);
      if (pick >= 5 && pick < 10) send_word(CMD_FETCH, 2'd1, 1'b0, st);
      if (pick >= 10 && pick < 15) begin
        load_seq(len, 0);
        send_word(CMD_FETCH, 2'd2, 1'b0, st);
        load_seq(len, 0);                          // restart mid-selection
      end else begin
        load_seq(len, 0);
      end
      fetch_all($urandom_range(0, 1));
      if (pick >= 90) drain();
    end
  endtask

  always @(negedge clk)
    out_ready <= calm || $urandom_range(0, 99) >= 23;

  always @(posedge clk) begin
    res_word_t exp_w;
    if (rst_n && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected word st=%0d pos=%0d", out_status, out_kmer_pos);
      end else begin
        exp_w = pending_words.pop_front();
        if (exp_w.status == dms_pkg::ST_KMER) n_kmers++;
        if (out_status !== exp_w.status || out_kmer_pos !== exp_w.pos ||
            out_kmer_bits !== exp_w.bits) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch: exp st=%0d pos=%0d bits=%h got st=%0d pos=%0d bits=%h",
                     exp_w.status, exp_w.pos, exp_w.bits,
                     out_status, out_kmer_pos, out_kmer_bits);
        end
      end
    end
  end

  initial begin
    #300000000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    hard_r = 4; klen_r = 16; wlen_r = 32;
    seq_len = 0; crit = 0; scan_at = 0; last_hit = 0; sel_phase = dms_pkg::PH_LOAD;
    foreach (win_open[j]) win_open[j] = 1'b0;
    foreach (seq_mem[j]) seq_mem[j] = 2'd0;
    n_items = 0; n_kmers = 0; n_bad = 0; calm = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_bad_geometry();
    test_overflow();
    test_random(1950);
    drain();
    repeat (200) @(posedge clk);
    if (pending_words.size() != 0) n_bad++;
    $display("ran %0d words, %0d minimisers checked, incl. overflow and geometry errors",
             n_items, n_kmers);
    if (n_bad == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- dna_minimiser_selector_unit.f -----
design/dms_pkg.sv
design/dms_dp.sv
design/dms_ctrl.sv
design/dna_minimiser_selector_unit.sv
tb/tb.sv
